FILE: rtl/insertion_sorter_assert.svh
// Assertion macros for the insertion sorter.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ISRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("insertion sorter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ISRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("insertion sorter: next-cycle check failed");

`endif

FILE: rtl/isrt_pkg.sv
// Shared types and constants of the insertion sorter.
package isrt_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               end_of_set;
		logic               overflow;
	} out_item_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} isrt_state_t;

	typedef struct packed {
		logic insert;
		logic mark_drop;
		logic shift_out;
	} isrt_cmd_t;

	typedef struct packed {
		logic full;
		logic one_left;
	} isrt_stat_t;

endpackage

FILE: rtl/isrt_ctrl.sv
// Controller state machine of the insertion sorter.
module isrt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  isrt_pkg::isrt_stat_t stat,
	output isrt_pkg::isrt_cmd_t  cmd
);
	import isrt_pkg::*;

	isrt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_FILL: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.insert    = !stat.full;
					cmd.mark_drop = stat.full;
					if (in_last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.shift_out = 1'b1;
					if (stat.one_left) begin
						state_d = ST_FILL;
					end
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

endmodule

FILE: rtl/isrt_dpath.sv
// Shift-insertion register array, fill count and drop flag.
module isrt_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [31:0]  in_value,
	input  isrt_pkg::isrt_cmd_t  cmd,
	output isrt_pkg::isrt_stat_t stat,
	output isrt_pkg::out_item_t  out_item
);
	import isrt_pkg::*;

	logic signed [31:0] cell_q [CAPACITY];
	logic [CNT_W-1:0]   count_q;
	logic               dropped_q;
	logic [CAPACITY-1:0] take;

	// A cell takes part in the insert when it is empty or holds a greater value.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			take[i] = (CNT_W'(i) >= count_q) || (cell_q[i] > in_value);
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (cmd.insert && take[g]) begin
					cell_q[g] <= in_value;
				end else if (cmd.shift_out) begin
					cell_q[g] <= cell_q[g+1];
				end
			end
		end else if (g == CAPACITY - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (cmd.insert && take[g]) begin
					cell_q[g] <= take[g-1] ? cell_q[g-1] : in_value;
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (cmd.insert && take[g]) begin
					cell_q[g] <= take[g-1] ? cell_q[g-1] : in_value;
				end else if (cmd.shift_out) begin
					cell_q[g] <= cell_q[g+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.shift_out) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.mark_drop) begin
				dropped_q <= 1'b1;
			end else if (cmd.shift_out && stat.one_left) begin
				dropped_q <= 1'b0;
			end
		end
	end

	assign stat.full     = (count_q == CNT_W'(CAPACITY));
	assign stat.one_left = (count_q == CNT_W'(1));

	assign out_item.sorted_value = cell_q[0];
	assign out_item.end_of_set   = stat.one_left;
	assign out_item.overflow     = dropped_q;

endmodule

FILE: rtl/insertion_sorter.sv
// Top level of the stable ascending insertion sorter.
//
// Input channel (in_valid / in_ready / in_data): one word per value. Each
// accepted word is inserted into a row of CAPACITY
// registers, behind every held value less than or equal to it, so equal
// values keep their arrival order. While filling, in_ready stays high and
// one word is taken every cycle.
// A word with last set closes the set. The block then stops taking input and
// drains the row on the output channel (out_valid / out_ready / out_data),
// lowest value first, one word per cycle while out_ready is high. The first
// result appears in the cycle after the last word is taken; after the final
// result is taken, input is taken again in the cycle after that.
// end_of_set marks the final result; overflow is set on every result of a
// set in which words arrived while the row was full (those words are lost).
// A stalled receiver simply holds the current result; nothing is lost.
// Reset empties the row and clears the overflow flag; the row contents are
// not cleared, as only filled positions are ever read.
module insertion_sorter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  isrt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output isrt_pkg::out_item_t out_data
);
	import isrt_pkg::*;

	`include "insertion_sorter_assert.svh"

	isrt_cmd_t  cmd;
	isrt_stat_t stat;

	// Control: fill / drain sequencing.
	isrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_data.last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: the sorted row, its fill count and the drop flag.
	isrt_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_value (in_data.value),
		.cmd      (cmd),
		.stat     (stat),
		.out_item (out_data)
	);

	// Never fill and drain in the same cycle.
	`ISRT_ASSERT_NOW(a_no_overlap, clk, arst_n, in_ready, !out_valid)
	// Drop a word only when the row is full.
	`ISRT_ASSERT_NOW(a_drop_when_full, clk, arst_n, cmd.mark_drop, stat.full && !cmd.insert)
	// After the final result, take input again.
	`ISRT_ASSERT_NEXT(a_resume_fill, clk, arst_n,
		out_valid && out_ready && out_data.end_of_set, in_ready)
	// Mid-set, the next result follows.
	`ISRT_ASSERT_NEXT(a_drain_continues, clk, arst_n,
		out_valid && out_ready && !out_data.end_of_set, out_valid)

endmodule
